// File: hw/rtl/rtcl_pkg.sv
package rtcl_pkg;

   // request function codes
   typedef enum logic [1:0] {
      FUNC_TICK  = 2'd0,
      FUNC_READ  = 2'd1,
      FUNC_WRITE = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   // register selects
   typedef enum logic [2:0] {
      SEL_SEC    = 3'd0,
      SEL_MIN    = 3'd1,
      SEL_HOUR   = 3'd2,
      SEL_DAY_HI = 3'd3,
      SEL_DAY_LO = 3'd4,
      SEL_CTRL   = 3'd5,
      SEL_LATCH  = 3'd6,
      SEL_SPARE  = 3'd7
   } sel_type;

   localparam int unsigned SEC_W  = 6;
   localparam int unsigned MIN_W  = 6;
   localparam int unsigned HOUR_W = 5;
   localparam int unsigned DAY_W  = 16;
   localparam int unsigned CTRL_W = 3;
   localparam int unsigned DATA_W = 8;

   localparam logic [SEC_W-1:0]  SEC_LAST  = SEC_W'(59);
   localparam logic [MIN_W-1:0]  MIN_LAST  = MIN_W'(59);
   localparam logic [HOUR_W-1:0] HOUR_LAST = HOUR_W'(23);

   localparam logic [CTRL_W-1:0] CTRL_MASK  = 3'b101;
   localparam logic [CTRL_W-1:0] CTRL_RESET = 3'b001;
   localparam int unsigned       CTRL_EN    = 0;

   // one accepted request word as seen by the register file
   typedef struct packed {
      logic              valid;
      logic [1:0]        func;
      logic [2:0]        sel;
      logic [DATA_W-1:0] data;
   } cmd_type;

endpackage

// File: hw/rtl/rtcl_regs.sv
module rtcl_regs (
   input  logic                       clock,
   input  logic                       reset,
   input  rtcl_pkg::cmd_type          cmd,
   output logic [rtcl_pkg::DATA_W-1:0] read_data
);

   logic [rtcl_pkg::SEC_W-1:0]  sec_ff, sec_in;
   logic [rtcl_pkg::MIN_W-1:0]  min_ff, min_in;
   logic [rtcl_pkg::HOUR_W-1:0] hour_ff, hour_in;
   logic [rtcl_pkg::DAY_W-1:0]  day_ff, day_in;
   logic [rtcl_pkg::SEC_W-1:0]  held_sec_ff, held_sec_in;
   logic [rtcl_pkg::MIN_W-1:0]  held_min_ff, held_min_in;
   logic [rtcl_pkg::HOUR_W-1:0] held_hour_ff, held_hour_in;
   logic [rtcl_pkg::DAY_W-1:0]  held_day_ff, held_day_in;
   logic                        held_valid_ff, held_valid_in;
   logic [rtcl_pkg::CTRL_W-1:0] ctrl_ff, ctrl_in;

   logic [rtcl_pkg::SEC_W-1:0]  rd_sec;
   logic [rtcl_pkg::MIN_W-1:0]  rd_min;
   logic [rtcl_pkg::HOUR_W-1:0] rd_hour;
   logic [rtcl_pkg::DAY_W-1:0]  rd_day;

   // read side: held copy wins once latched
   always_comb begin
      rd_sec  = held_valid_ff ? held_sec_ff  : sec_ff;
      rd_min  = held_valid_ff ? held_min_ff  : min_ff;
      rd_hour = held_valid_ff ? held_hour_ff : hour_ff;
      rd_day  = held_valid_ff ? held_day_ff  : day_ff;
      read_data = '0;
      if (cmd.func == rtcl_pkg::FUNC_READ) begin
         unique case (rtcl_pkg::sel_type'(cmd.sel))
            rtcl_pkg::SEL_SEC:    read_data = rtcl_pkg::DATA_W'(rd_sec);
            rtcl_pkg::SEL_MIN:    read_data = rtcl_pkg::DATA_W'(rd_min);
            rtcl_pkg::SEL_HOUR:   read_data = rtcl_pkg::DATA_W'(rd_hour);
            rtcl_pkg::SEL_DAY_HI: read_data = rd_day[15:8];
            rtcl_pkg::SEL_DAY_LO: read_data = rd_day[7:0];
            rtcl_pkg::SEL_CTRL:   read_data = rtcl_pkg::DATA_W'(ctrl_ff);
            default:              read_data = '0;
         endcase
      end
   end

   // update side
   always_comb begin
      sec_in        = sec_ff;
      min_in        = min_ff;
      hour_in       = hour_ff;
      day_in        = day_ff;
      held_sec_in   = held_sec_ff;
      held_min_in   = held_min_ff;
      held_hour_in  = held_hour_ff;
      held_day_in   = held_day_ff;
      held_valid_in = held_valid_ff;
      ctrl_in       = ctrl_ff;
      if (cmd.valid) begin
         if (cmd.func == rtcl_pkg::FUNC_TICK) begin
            if (ctrl_ff[rtcl_pkg::CTRL_EN]) begin
               // cascaded carry through sec, min, hour, day
               if (sec_ff != rtcl_pkg::SEC_LAST) begin
                  sec_in = sec_ff + 1'b1;
               end else begin
                  sec_in = '0;
                  if (min_ff != rtcl_pkg::MIN_LAST) begin
                     min_in = min_ff + 1'b1;
                  end else begin
                     min_in = '0;
                     if (hour_ff != rtcl_pkg::HOUR_LAST) begin
                        hour_in = hour_ff + 1'b1;
                     end else begin
                        hour_in = '0;
                        day_in  = day_ff + 1'b1;
                     end
                  end
               end
            end
         end else if (cmd.func == rtcl_pkg::FUNC_WRITE) begin
            if (cmd.sel == rtcl_pkg::SEL_CTRL) begin
               ctrl_in = cmd.data[rtcl_pkg::CTRL_W-1:0] & rtcl_pkg::CTRL_MASK;
               if (cmd.data[rtcl_pkg::CTRL_EN]) begin
                  sec_in  = '0;
                  min_in  = '0;
                  hour_in = '0;
                  day_in  = '0;
               end
            end else if (cmd.sel == rtcl_pkg::SEL_LATCH) begin
               held_sec_in   = sec_ff;
               held_min_in   = min_ff;
               held_hour_in  = hour_ff;
               held_day_in   = day_ff;
               held_valid_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sec_ff        <= '0;
         min_ff        <= '0;
         hour_ff       <= '0;
         day_ff        <= '0;
         held_sec_ff   <= '0;
         held_min_ff   <= '0;
         held_hour_ff  <= '0;
         held_day_ff   <= '0;
         held_valid_ff <= 1'b0;
         ctrl_ff       <= rtcl_pkg::CTRL_RESET;
      end else begin
         sec_ff        <= sec_in;
         min_ff        <= min_in;
         hour_ff       <= hour_in;
         day_ff        <= day_in;
         held_sec_ff   <= held_sec_in;
         held_min_ff   <= held_min_in;
         held_hour_ff  <= held_hour_in;
         held_day_ff   <= held_day_in;
         held_valid_ff <= held_valid_in;
         ctrl_ff       <= ctrl_in;
      end
   end

endmodule

// File: hw/rtl/rtc_time_counter_with_latch_unit.sv
// response word is registered in the output register, or in the skid stage while the output is stalled
// throughput: one request word per cycle while the skid stage is not full (req_stall low)
// a two-entry output buffer keeps taking requests while one response waits
// reset (synchronous, active high): time and held registers zero, latch flag
// clear, control = enable; no clearing pass, ready the cycle after reset
module rtc_time_counter_with_latch_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [2:0]  req_reg_sel,
   input  logic [7:0]  req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_data
);

   rtcl_pkg::cmd_type cmd;
   logic              push;
   logic [7:0]        new_data;

   // output register and skid stage
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_data_ff, out_data_in;
   logic       skid_valid_ff, skid_valid_in;
   logic [7:0] skid_data_ff, skid_data_in;
   logic       slot_free;

   // only a full skid stage holds off the requester
   assign req_stall = skid_valid_ff;
   assign push      = req_valid & ~req_stall;

   always_comb begin
      cmd.valid = push;
      cmd.func  = req_func;
      cmd.sel   = req_reg_sel;
      cmd.data  = req_write_data;
   end

   // counters, latch copy and control live here; read data is combinational
   rtcl_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .read_data (new_data)
   );

   // output slot frees when empty or its word is taken this cycle
   assign slot_free = ~out_valid_ff | ~rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (slot_free) begin
         if (skid_valid_ff) begin
            // older word moves up, new word (if any) takes the skid
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = push;
            skid_data_in  = new_data;
         end else begin
            out_valid_in = push;
            out_data_in  = new_data;
         end
      end else if (push) begin
         // output held by stall, park the new word
         skid_valid_in = 1'b1;
         skid_data_in  = new_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_read_data = out_data_ff;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   // clock and reset: reset held high from time zero
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #2 clock = ~clock;

   // request side, every input known from the start
   logic                        req_valid      = 1'b0;
   logic                        req_stall;
   logic [1:0]                  req_func       = '0;
   logic [2:0]                  req_reg_sel    = '0;
   logic [rtcl_pkg::DATA_W-1:0] req_write_data = '0;

   // response side
   logic                        rsp_valid;
   logic                        rsp_stall      = 1'b0;
   logic [rtcl_pkg::DATA_W-1:0] rsp_read_data;

   rtc_time_counter_with_latch_unit u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_reg_sel    (req_reg_sel),
      .req_write_data (req_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_data  (rsp_read_data)
   );

   // shadow copy of the clock registers, starting from the reset values
   logic [rtcl_pkg::SEC_W-1:0]  run_sec   = '0;
   logic [rtcl_pkg::MIN_W-1:0]  run_min   = '0;
   logic [rtcl_pkg::HOUR_W-1:0] run_hour  = '0;
   logic [rtcl_pkg::DAY_W-1:0]  run_day   = '0;
   logic [rtcl_pkg::SEC_W-1:0]  held_sec  = '0;
   logic [rtcl_pkg::MIN_W-1:0]  held_min  = '0;
   logic [rtcl_pkg::HOUR_W-1:0] held_hour = '0;
   logic [rtcl_pkg::DAY_W-1:0]  held_day  = '0;
   logic                        held_flag = 1'b0;
   logic [rtcl_pkg::CTRL_W-1:0] shadow_ctrl = rtcl_pkg::CTRL_RESET;

   // read data still owed by the block, oldest first
   logic [rtcl_pkg::DATA_W-1:0] expected_read_data [$];

   int mismatch_count = 0;
   int burst_left     = 0;
   logic [8:0] stall_phase = '0;

   // applies one accepted word to the shadow registers and returns the
   // read data the block should answer with (zero unless it is a read)
   function logic [rtcl_pkg::DATA_W-1:0] apply_shadow_word(rtcl_pkg::func_type f,
                                                           rtcl_pkg::sel_type s,
                                                           logic [rtcl_pkg::DATA_W-1:0] d);
      logic [rtcl_pkg::DATA_W-1:0] rd;
      logic [rtcl_pkg::SEC_W-1:0]  v_sec;
      logic [rtcl_pkg::MIN_W-1:0]  v_min;
      logic [rtcl_pkg::HOUR_W-1:0] v_hour;
      logic [rtcl_pkg::DAY_W-1:0]  v_day;
      rd = '0;
      case (f)
         rtcl_pkg::FUNC_TICK: begin
            // cascade sec -> min -> hour -> day, day wraps at 16 bits
            if (shadow_ctrl[rtcl_pkg::CTRL_EN]) begin
               if (run_sec != rtcl_pkg::SEC_LAST) run_sec = run_sec + 1'b1;
               else begin
                  run_sec = '0;
                  if (run_min != rtcl_pkg::MIN_LAST) run_min = run_min + 1'b1;
                  else begin
                     run_min = '0;
                     if (run_hour != rtcl_pkg::HOUR_LAST) run_hour = run_hour + 1'b1;
                     else begin
                        run_hour = '0;
                        run_day  = run_day + 1'b1;
                     end
                  end
               end
            end
         end
         rtcl_pkg::FUNC_READ: begin
            // once latched, time reads come from the held copy for good
            v_sec  = held_flag ? held_sec  : run_sec;
            v_min  = held_flag ? held_min  : run_min;
            v_hour = held_flag ? held_hour : run_hour;
            v_day  = held_flag ? held_day  : run_day;
            case (s)
               rtcl_pkg::SEL_SEC:    rd = rtcl_pkg::DATA_W'(v_sec);
               rtcl_pkg::SEL_MIN:    rd = rtcl_pkg::DATA_W'(v_min);
               rtcl_pkg::SEL_HOUR:   rd = rtcl_pkg::DATA_W'(v_hour);
               rtcl_pkg::SEL_DAY_HI: rd = v_day[15:8];
               rtcl_pkg::SEL_DAY_LO: rd = v_day[7:0];
               rtcl_pkg::SEL_CTRL:   rd = rtcl_pkg::DATA_W'(shadow_ctrl);
               default:              rd = '0;
            endcase
         end
         rtcl_pkg::FUNC_WRITE: begin
            if (s == rtcl_pkg::SEL_CTRL) begin
               shadow_ctrl = d[rtcl_pkg::CTRL_W-1:0] & rtcl_pkg::CTRL_MASK;
               // enabling restarts the time, disabling just freezes it
               if (shadow_ctrl[rtcl_pkg::CTRL_EN]) begin
                  run_sec  = '0;
                  run_min  = '0;
                  run_hour = '0;
                  run_day  = '0;
               end
            end else if (s == rtcl_pkg::SEL_LATCH) begin
               held_sec  = run_sec;
               held_min  = run_min;
               held_hour = run_hour;
               held_day  = run_day;
               held_flag = 1'b1;
            end
         end
         default: ;
      endcase
      return rd;
   endfunction

   // sends one request word; bursts of random length with random gaps
   task automatic send_word(input rtcl_pkg::func_type f, input rtcl_pkg::sel_type s,
                            input logic [rtcl_pkg::DATA_W-1:0] d);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         gap        = $urandom_range(1, 6);
         // now and then a long burst with no idling at all
         burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 24);
      end
      burst_left--;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= f;
      req_reg_sel    <= s;
      req_write_data <= d;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // accepted at this edge, its response cannot come before the next one
      expected_read_data.push_back(apply_shadow_word(f, s, d));
   endtask

   // sender holds off until every owed response has come back
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_read_data.size() != 0) @(posedge clock);
   endtask

   task automatic report_mismatch(input string what,
                                  input logic [rtcl_pkg::DATA_W-1:0] exp_v,
                                  input logic [rtcl_pkg::DATA_W-1:0] got_v);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch: %s read_data expected %0h got %0h at %0t",
                  what, exp_v, got_v, $realtime);
   endtask

   // response checker: each accepted word against the oldest expectation
   always @(posedge clock) begin
      logic [rtcl_pkg::DATA_W-1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_read_data.size() == 0) begin
            report_mismatch("unexpected word", '0, rsp_read_data);
         end else begin
            want = expected_read_data.pop_front();
            if (rsp_read_data !== want) report_mismatch("word", want, rsp_read_data);
         end
      end
   end

   // receiver stall pattern: quiet, light, heavy and periodic stretches
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1'b1;
      case (stall_phase[8:7])
         2'd0: rsp_stall <= 1'b0;
         2'd1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2'd2: rsp_stall <= ($urandom_range(0, 9) < 6);
         default: rsp_stall <= (stall_phase[2:0] >= 3'd5);
      endcase
   end

   // reads of every time register, with a latch first so the held copy is fresh
   task automatic latch_and_read_time();
      send_word(rtcl_pkg::FUNC_WRITE, rtcl_pkg::SEL_LATCH,
                rtcl_pkg::DATA_W'($urandom_range(0, 255)));
      send_word(rtcl_pkg::FUNC_READ, rtcl_pkg::SEL_SEC, '0);
      send_word(rtcl_pkg::FUNC_READ, rtcl_pkg::SEL_MIN, '0);
      send_word(rtcl_pkg::FUNC_READ, rtcl_pkg::SEL_HOUR, '0);
      send_word(rtcl_pkg::FUNC_READ, rtcl_pkg::SEL_DAY_HI, '0);
      send_word(rtcl_pkg::FUNC_READ, rtcl_pkg::SEL_DAY_LO, '0);
   endtask

   // corner cases straight after reset
   task automatic test_directed();
      send_word(rtcl_pkg::FUNC_READ, rtcl_pkg::SEL_SEC, '0);
      send_word(rtcl_pkg::FUNC_READ, rtcl_pkg::SEL_CTRL, '0);     // reset value, enable set
      send_word(rtcl_pkg::FUNC_READ, rtcl_pkg::SEL_SPARE, 8'hFF); // unused select reads zero
      send_word(rtcl_pkg::FUNC_READ, rtcl_pkg::SEL_LATCH, '0);    // latch register reads zero
      send_word(rtcl_pkg::FUNC_TICK, rtcl_pkg::SEL_SEC, '0);
      send_word(rtcl_pkg::FUNC_TICK, rtcl_pkg::SEL_SPARE, 8'hFF);
      send_word(rtcl_pkg::FUNC_READ, rtcl_pkg::SEL_SEC, '0);
      send_word(rtcl_pkg::FUNC_WRITE, rtcl_pkg::SEL_SEC, 8'hFF);  // time registers read-only
      send_word(rtcl_pkg::FUNC_WRITE, rtcl_pkg::SEL_DAY_HI, 8'h00);
      send_word(rtcl_pkg::FUNC_WRITE, rtcl_pkg::SEL_SPARE, 8'hAA);
      send_word(rtcl_pkg::FUNC_NONE, rtcl_pkg::SEL_CTRL, 8'h55);  // spare function does nothing
      send_word(rtcl_pkg::FUNC_READ, rtcl_pkg::SEL_MIN, '0);
      send_word(rtcl_pkg::FUNC_READ, rtcl_pkg::SEL_HOUR, '0);
      send_word(rtcl_pkg::FUNC_READ, rtcl_pkg::SEL_DAY_HI, '0);
      send_word(rtcl_pkg::FUNC_READ, rtcl_pkg::SEL_DAY_LO, '0);
      send_word(rtcl_pkg::FUNC_WRITE, rtcl_pkg::SEL_CTRL, 8'hFA); // disable, time stays frozen
      send_word(rtcl_pkg::FUNC_TICK, rtcl_pkg::SEL_SEC, '0);      // ignored while disabled
      send_word(rtcl_pkg::FUNC_READ, rtcl_pkg::SEL_SEC, '0);
      send_word(rtcl_pkg::FUNC_WRITE, rtcl_pkg::SEL_LATCH, 8'h3C); // latch of frozen time
      send_word(rtcl_pkg::FUNC_WRITE, rtcl_pkg::SEL_CTRL, 8'hFF); // enable again, time restarts
      send_word(rtcl_pkg::FUNC_TICK, rtcl_pkg::SEL_SEC, '0);
      send_word(rtcl_pkg::FUNC_READ, rtcl_pkg::SEL_SEC, '0);      // still the held value
      send_word(rtcl_pkg::FUNC_READ, rtcl_pkg::SEL_CTRL, '0);
      send_word(rtcl_pkg::FUNC_WRITE, rtcl_pkg::SEL_LATCH, 8'h00);
      send_word(rtcl_pkg::FUNC_READ, rtcl_pkg::SEL_SEC, '0);
   endtask

   // a couple of minutes of ticks so the seconds wrap and carry into minutes
   task automatic test_minute_rollover();
      send_word(rtcl_pkg::FUNC_WRITE, rtcl_pkg::SEL_CTRL, 8'h01);
      for (int t = 1; t <= 125; t++) begin
         send_word(rtcl_pkg::FUNC_TICK, rtcl_pkg::sel_type'($urandom_range(0, 7)),
                   rtcl_pkg::DATA_W'($urandom_range(0, 255)));
         if (t % 40 == 0 || t >= 120) latch_and_read_time();
      end
   endtask

   // mostly ticks and random reads, with latch writes and noise mixed in
   task automatic test_random_mix();
      int pick;
      for (int n = 0; n < 1300; n++) begin
         if (n == 650) drain_responses();
         pick = $urandom_range(0, 99);
         if (pick < 50)
            send_word(rtcl_pkg::FUNC_TICK, rtcl_pkg::sel_type'($urandom_range(0, 7)),
                      rtcl_pkg::DATA_W'($urandom_range(0, 255)));
         else if (pick < 75)
            send_word(rtcl_pkg::FUNC_READ, rtcl_pkg::sel_type'($urandom_range(0, 7)),
                      rtcl_pkg::DATA_W'($urandom_range(0, 255)));
         else if (pick < 85)
            send_word(rtcl_pkg::FUNC_WRITE, rtcl_pkg::SEL_LATCH,
                      rtcl_pkg::DATA_W'($urandom_range(0, 255)));
         else if (pick < 92)
            send_word(rtcl_pkg::FUNC_WRITE, rtcl_pkg::sel_type'($urandom_range(0, 7)),
                      rtcl_pkg::DATA_W'($urandom_range(0, 255)));
         else if (pick < 96)
            send_word(rtcl_pkg::FUNC_WRITE, rtcl_pkg::SEL_CTRL,
                      rtcl_pkg::DATA_W'($urandom_range(0, 255)));
         else
            send_word(rtcl_pkg::FUNC_NONE, rtcl_pkg::sel_type'($urandom_range(0, 7)),
                      rtcl_pkg::DATA_W'($urandom_range(0, 255)));
      end
   endtask

   // test sequence
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      drain_responses();
      test_minute_rollover();
      drain_responses();
      test_random_mix();
      drain_responses();
      // wait on to catch any stray response word
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && expected_read_data.size() == 0) begin
         $display("rtc_time_counter_with_latch_unit test passed");
      end else begin
         $display("rtc_time_counter_with_latch_unit test failed");
      end
      $finish;
   end

   // overall time limit, far beyond the slowest correct run
   initial begin
      #20000000;
      $display("rtc_time_counter_with_latch_unit test failed");
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/rtcl_pkg.sv
hw/rtl/rtcl_regs.sv
hw/rtl/rtc_time_counter_with_latch_unit.sv
tb/tb_top.sv
